// ----- design/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// types and constants shared by the stroke cycle sequencer and its step logic
// ----------------------------------------------------------------------------
package scs_pkg;

    // sequencer phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_HOME     = 7'b0000010,
        PH_POSITION = 7'b0000100,
        PH_SHORT    = 7'b0001000,
        PH_LONG     = 7'b0010000,
        PH_COMPLETE = 7'b0100000,
        PH_FAULT    = 7'b1000000
    } phase_t;

    // phase codes as reported on the result beat
    localparam logic [2:0] CODE_IDLE     = 3'd0;
    localparam logic [2:0] CODE_HOME     = 3'd1;
    localparam logic [2:0] CODE_POSITION = 3'd2;
    localparam logic [2:0] CODE_SHORT    = 3'd3;
    localparam logic [2:0] CODE_LONG     = 3'd4;
    localparam logic [2:0] CODE_COMPLETE = 3'd5;
    localparam logic [2:0] CODE_FAULT    = 3'd6;

    // event codes
    typedef enum logic [2:0] {
        REQ_START     = 3'd0,
        REQ_HOME_DONE = 3'd1,
        REQ_MOVE_DONE = 3'd2,
        REQ_FAULT     = 3'd3,
        REQ_TAKE      = 3'd4
    } req_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TRAVEL_LENGTH   = 3'd0,
        CFG_SHORT_COUNT     = 3'd1,
        CFG_SHORT_LENGTH    = 3'd2,
        CFG_LONG_COUNT      = 3'd3,
        CFG_LONG_LENGTH     = 3'd4,
        CFG_POSITION_SPEED  = 3'd5,
        CFG_FAST_COUNT      = 3'd6,
        CFG_STROKE_SPEEDS   = 3'd7
    } cfg_idx_t;

    localparam logic [7:0] SPEED_MIN   = 8'd10;
    localparam logic [7:0] SPEED_MAX   = 8'd95;
    localparam logic [6:0] SPEED_MIN_7 = 7'd10;
    localparam logic [6:0] SPEED_MAX_7 = 7'd95;

    typedef struct packed {
        logic [7:0]  travel_length;
        logic [7:0]  short_count;
        logic [7:0]  short_length;
        logic [7:0]  long_count;
        logic [7:0]  long_length;
        logic [7:0]  position_speed;
        logic [7:0]  fast_count;
        logic [31:0] stroke_speeds;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        travel_length:   8'd100,
        short_count:     8'd4,
        short_length:    8'd40,
        long_count:      8'd4,
        long_length:     8'd100,
        position_speed:  8'd75,
        fast_count:      8'd2,
        stroke_speeds:   32'h3C5A_2846
    };

    typedef struct packed {
        phase_t     phase;
        logic [7:0] stroke;
        logic [7:0] target;
        logic [6:0] speed;
        logic       extend;
        logic       pending;
        logic [7:0] fault;
    } state_t;

    typedef struct packed {
        logic       command_valid;
        logic [7:0] target_position;
        logic [6:0] target_speed;
        logic [2:0] phase;
        logic [7:0] stroke_index;
        logic       extending;
        logic       pending;
        logic [7:0] fault_value;
    } result_t;

    function automatic logic [6:0] clamp_speed(input logic [7:0] s);
        logic [6:0] r;
        if (s < SPEED_MIN) begin
            r = SPEED_MIN_7;
        end else if (s > SPEED_MAX) begin
            r = SPEED_MAX_7;
        end else begin
            r = s[6:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] c;
        case (p)
            PH_IDLE:     c = CODE_IDLE;
            PH_HOME:     c = CODE_HOME;
            PH_POSITION: c = CODE_POSITION;
            PH_SHORT:    c = CODE_SHORT;
            PH_LONG:     c = CODE_LONG;
            PH_COMPLETE: c = CODE_COMPLETE;
            PH_FAULT:    c = CODE_FAULT;
            default:     c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ----- design/scs_step.sv -----
// ----------------------------------------------------------------------------
// scs_step
// next-state and result logic for one sequencer event
// ----------------------------------------------------------------------------
module scs_step (
    input  scs_pkg::cfg_t    cfg,
    input  scs_pkg::state_t  state,
    input  logic [2:0]       req_type,
    input  logic [7:0]       fault_code,
    output scs_pkg::state_t  state_next,
    output scs_pkg::result_t result
);
    import scs_pkg::*;

    req_t       req;
    logic [7:0] act_len;
    logic [7:0] short_len;
    logic [7:0] long_len;
    logic [7:0] short_low;
    logic [7:0] long_low;
    logic       short_on;
    logic       long_on;

    // next stroke decision for a move done
    logic       q_en;
    logic       q_fin;
    logic       q_short;
    logic [7:0] q_num;
    logic       q_ext;

    // next stroke target and speed
    logic [7:0] q_len;
    logic [7:0] q_low;
    logic [7:0] q_target;
    logic       q_fast;
    logic [7:0] q_spd_raw;
    logic       take;

    assign req = req_t'(req_type);

    // validated lengths and stroke windows
    always_comb begin
        act_len   = (cfg.travel_length == 8'd0) ? 8'd1 : cfg.travel_length;
        short_len = (cfg.short_length > act_len) ? act_len : cfg.short_length;
        long_len  = (cfg.long_length > act_len) ? act_len : cfg.long_length;
        short_low = (act_len - short_len) >> 1;
        long_low  = (act_len - long_len) >> 1;
        short_on  = (cfg.short_count != 8'd0) && (short_len != 8'd0);
        long_on   = (cfg.long_count != 8'd0) && (long_len != 8'd0);
    end

    always_comb begin
        q_en    = 1'b0;
        q_fin   = 1'b0;
        q_short = 1'b1;
        q_num   = 8'd1;
        q_ext   = 1'b1;
        case (state.phase)
            PH_POSITION: begin
                q_en    = 1'b1;
                q_short = short_on;
            end
            PH_SHORT: begin
                q_ext = ~state.extend;
                if (state.stroke < cfg.short_count) begin
                    q_en  = 1'b1;
                    q_num = state.stroke + 8'd1;
                end else if (long_on) begin
                    q_en    = 1'b1;
                    q_short = 1'b0;
                end else begin
                    q_fin = 1'b1;
                end
            end
            PH_LONG: begin
                q_ext   = ~state.extend;
                q_short = 1'b0;
                if (state.stroke < cfg.long_count) begin
                    q_en  = 1'b1;
                    q_num = state.stroke + 8'd1;
                end else begin
                    q_fin = 1'b1;
                end
            end
            default: begin
                q_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        q_len    = q_short ? short_len : long_len;
        q_low    = q_short ? short_low : long_low;
        q_target = q_ext ? (q_low + q_len) : q_low;
        q_fast   = (q_num <= cfg.fast_count);
        case ({~q_short, ~q_fast})
            2'b00:   q_spd_raw = cfg.stroke_speeds[7:0];
            2'b01:   q_spd_raw = cfg.stroke_speeds[15:8];
            2'b10:   q_spd_raw = cfg.stroke_speeds[23:16];
            2'b11:   q_spd_raw = cfg.stroke_speeds[31:24];
            default: q_spd_raw = cfg.stroke_speeds[7:0];
        endcase
    end

    always_comb begin
        state_next = state;
        take       = 1'b0;
        case (req)
            REQ_START: begin
                state_next.phase   = PH_HOME;
                state_next.stroke  = 8'd0;
                state_next.target  = 8'd0;
                state_next.speed   = 7'd0;
                state_next.extend  = 1'b0;
                state_next.pending = 1'b0;
                state_next.fault   = 8'd0;
            end
            REQ_HOME_DONE: begin
                if (short_on || long_on) begin
                    state_next.phase   = PH_POSITION;
                    state_next.stroke  = 8'd0;
                    state_next.target  = short_on ? short_low : long_low;
                    state_next.speed   = clamp_speed(cfg.position_speed);
                    state_next.extend  = 1'b1;
                    state_next.pending = 1'b1;
                end else begin
                    state_next.phase = PH_COMPLETE;
                end
            end
            REQ_MOVE_DONE: begin
                if (q_en) begin
                    state_next.phase   = q_short ? PH_SHORT : PH_LONG;
                    state_next.stroke  = q_num;
                    state_next.extend  = q_ext;
                    state_next.target  = q_target;
                    state_next.speed   = clamp_speed(q_spd_raw);
                    state_next.pending = 1'b1;
                end else if (q_fin) begin
                    state_next.phase   = PH_COMPLETE;
                    state_next.pending = 1'b0;
                end
            end
            REQ_FAULT: begin
                state_next.phase   = PH_FAULT;
                state_next.fault   = fault_code;
                state_next.pending = 1'b0;
            end
            REQ_TAKE: begin
                if (state.pending) begin
                    take               = 1'b1;
                    state_next.pending = 1'b0;
                end
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.command_valid   = take;
        result.target_position = take ? state.target : 8'd0;
        result.target_speed    = take ? state.speed : 7'd0;
        result.phase           = phase_code(state_next.phase);
        result.stroke_index    = state_next.stroke;
        result.extending       = state_next.extend;
        result.pending         = state_next.pending;
        result.fault_value     = state_next.fault;
    end

endmodule

// ----- design/stroke_cycle_sequencer.sv -----
// ----------------------------------------------------------------------------
// stroke_cycle_sequencer
// steps a linear actuator through homing, positioning and stroke phases
// ----------------------------------------------------------------------------
// Each input beat is one event (start, home done, move done, fault or take
// command) and yields exactly one result beat with the command taken, if any,
// and the sequencer status after the event. The block takes one event every
// clock cycle unless m_tready holds back a full result register; the accepting
// edge loads the input register and a later edge, once the result register
// can move on, loads the result register through the step logic. The rate is
// set by the update of the sequencer state, which every event reads and writes.
// A full result register holds back the input side only while m_tready is low.
// Configuration writes are taken on every cycle and should be issued only while
// no event is in flight.
module stroke_cycle_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // event channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // req_type[2:0], fault_code[10:3], zero fill
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // target_position[7:0], target_speed[14:8], phase[17:15],
    // stroke_index[25:18], extending[26], pending[27], fault_value[35:28],
    // zero fill
    output logic [39:0] m_tdata,
    output logic        m_tuser,   // command_valid
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import scs_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t out_reg;

    logic       in_valid_reg;
    logic [2:0] in_req_reg;
    logic [7:0] in_code_reg;
    logic       out_valid_reg;
    logic       advance;

    // configuration registers, raw values kept and validated where used
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TRAVEL_LENGTH:   cfg_reg.travel_length   <= cfg_data[7:0];
                CFG_SHORT_COUNT:     cfg_reg.short_count     <= cfg_data[7:0];
                CFG_SHORT_LENGTH:    cfg_reg.short_length    <= cfg_data[7:0];
                CFG_LONG_COUNT:      cfg_reg.long_count      <= cfg_data[7:0];
                CFG_LONG_LENGTH:     cfg_reg.long_length     <= cfg_data[7:0];
                CFG_POSITION_SPEED:  cfg_reg.position_speed  <= cfg_data[7:0];
                CFG_FAST_COUNT:      cfg_reg.fast_count      <= cfg_data[7:0];
                CFG_STROKE_SPEEDS:   cfg_reg.stroke_speeds   <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // the result register moves on when empty or when its beat is taken;
    // the input register then hands its event on
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg  <= s_tdata[2:0];
            in_code_reg <= s_tdata[10:3];
        end
    end

    scs_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req_type   (in_req_reg),
        .fault_code (in_code_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // sequencer state, updated once per event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase   <= PH_IDLE;
            state_reg.stroke  <= 8'd0;
            state_reg.target  <= 8'd0;
            state_reg.speed   <= 7'd0;
            state_reg.extend  <= 1'b0;
            state_reg.pending <= 1'b0;
            state_reg.fault   <= 8'd0;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.command_valid;
    assign m_tdata  = {4'd0,
                       out_reg.fault_value,
                       out_reg.pending,
                       out_reg.extending,
                       out_reg.stroke_index,
                       out_reg.phase,
                       out_reg.target_speed,
                       out_reg.target_position};

    // an event in the input register always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("event lost between input and result registers");

    // input side stalls only behind a full, stalled result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without back pressure");

    // a fault drops the pending command and nothing queues a new one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_FAULT) |-> !state_reg.pending)
        else $error("command pending in fault phase");

    // a command is queued only by a positioning or stroke move
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.pending) |-> (state_reg.phase == PH_POSITION ||
                                      state_reg.phase == PH_SHORT ||
                                      state_reg.phase == PH_LONG))
        else $error("command queued outside a move phase");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stroke cycle sequencer
// ----------------------------------------------------------------------------
// Event beats go in on the s_ channel and result beats are checked on the m_
// channel, both with random stalls. A stroke tracker class follows the
// sequencer state and the register settings. It works out the status beat
// each accepted event should give, and compares the result beats in order.
// Register writes happen only while no event is in flight.
import scs_pkg::*;

class stroke_tracker;
    cfg_t        regs;
    logic [2:0]  ph;
    logic [7:0]  stroke;
    logic [7:0]  target;
    logic [6:0]  speed;
    logic        ext;
    logic        pend;
    logic [7:0]  fault;
    result_t     status_due[$];
    int unsigned errors;

    function new();
        regs   = CFG_RESET;
        errors = 0;
        clear_all();
    endfunction

    function void clear_all();
        ph     = CODE_IDLE;
        stroke = '0;
        target = '0;
        speed  = '0;
        ext    = 1'b0;
        pend   = 1'b0;
        fault  = '0;
    endfunction

    // 8-bit registers keep the low byte only
    function void set_reg(cfg_idx_t idx, logic [31:0] d);
        case (idx)
            CFG_TRAVEL_LENGTH:   regs.travel_length   = d[7:0];
            CFG_SHORT_COUNT:     regs.short_count     = d[7:0];
            CFG_SHORT_LENGTH:    regs.short_length    = d[7:0];
            CFG_LONG_COUNT:      regs.long_count      = d[7:0];
            CFG_LONG_LENGTH:     regs.long_length     = d[7:0];
            CFG_POSITION_SPEED:  regs.position_speed  = d[7:0];
            CFG_FAST_COUNT:      regs.fast_count      = d[7:0];
            CFG_STROKE_SPEEDS:   regs.stroke_speeds   = d;
            default: ;
        endcase
    endfunction

    // zero travel is treated as one
    function int travel();
        return (regs.travel_length == 0) ? 1 : int'(regs.travel_length);
    endfunction

    function int stroke_len(bit is_short);
        int l;
        int a;
        l = is_short ? int'(regs.short_length) : int'(regs.long_length);
        a = travel();
        return (l > a) ? a : l;
    endfunction

    function bit short_on();
        return regs.short_count != 0 && stroke_len(1'b1) != 0;
    endfunction

    function bit long_on();
        return regs.long_count != 0 && stroke_len(1'b0) != 0;
    endfunction

    function int window_low(bit is_short);
        return (travel() - stroke_len(is_short)) / 2;
    endfunction

    function logic [6:0] bound_speed(logic [7:0] s);
        if (s < SPEED_MIN) return 7'(SPEED_MIN);
        if (s > SPEED_MAX) return 7'(SPEED_MAX);
        return s[6:0];
    endfunction

    function void load_position(bit is_short);
        ph     = CODE_POSITION;
        stroke = '0;
        target = 8'(window_low(is_short));
        speed  = bound_speed(regs.position_speed);
        ext    = 1'b1;
        pend   = 1'b1;
    endfunction

    function void load_stroke(bit is_short, int num, bit dir);
        int          low;
        bit          fast;
        int          sel;
        logic [31:0] sh;
        low    = window_low(is_short);
        fast   = num <= int'(regs.fast_count);
        sel    = (is_short ? 0 : 2) + (fast ? 0 : 1);
        sh     = regs.stroke_speeds >> (8 * sel);
        ph     = is_short ? CODE_SHORT : CODE_LONG;
        stroke = 8'(num);
        ext    = dir;
        target = 8'(dir ? low + stroke_len(is_short) : low);
        speed  = bound_speed(sh[7:0]);
        pend   = 1'b1;
    endfunction

    function void note_event(logic [2:0] req, logic [7:0] code);
        result_t r;
        r = '0;
        case (req)
            REQ_START: begin
                clear_all();
                ph = CODE_HOME;
            end
            REQ_HOME_DONE: begin
                // acted on in every phase; with nothing enabled pend stays
                if (short_on()) load_position(1'b1);
                else if (long_on()) load_position(1'b0);
                else ph = CODE_COMPLETE;
            end
            REQ_MOVE_DONE: begin
                if (ph == CODE_POSITION) begin
                    load_stroke(short_on(), 1, 1'b1);
                end else if (ph == CODE_SHORT) begin
                    if (stroke < regs.short_count) load_stroke(1'b1, int'(stroke) + 1, !ext);
                    else if (long_on()) load_stroke(1'b0, 1, !ext);
                    else begin
                        ph   = CODE_COMPLETE;
                        pend = 1'b0;
                    end
                end else if (ph == CODE_LONG) begin
                    if (stroke < regs.long_count) load_stroke(1'b0, int'(stroke) + 1, !ext);
                    else begin
                        ph   = CODE_COMPLETE;
                        pend = 1'b0;
                    end
                end
            end
            REQ_FAULT: begin
                ph    = CODE_FAULT;
                fault = code;
                pend  = 1'b0;
            end
            REQ_TAKE: begin
                if (pend) begin
                    r.command_valid   = 1'b1;
                    r.target_position = target;
                    r.target_speed    = speed;
                    pend              = 1'b0;
                end
            end
            default: ;
        endcase
        r.phase        = ph;
        r.stroke_index = stroke;
        r.extending    = ext;
        r.pending      = pend;
        r.fault_value  = fault;
        status_due.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_status(result_t got);
        result_t want;
        if (status_due.size() == 0) begin
            $display("%0t: result beat with no event outstanding, expected none, actual %h",
                     $time, got);
            errors++;
            return;
        end
        want = status_due.pop_front();
        compare("command_valid", 8'(want.command_valid), 8'(got.command_valid));
        compare("target_position", want.target_position, got.target_position);
        compare("target_speed", 8'(want.target_speed), 8'(got.target_speed));
        compare("phase", 8'(want.phase), 8'(got.phase));
        compare("stroke_index", want.stroke_index, got.stroke_index);
        compare("extending", 8'(want.extending), 8'(got.extending));
        compare("pending", 8'(want.pending), 8'(got.pending));
        compare("fault_value", want.fault_value, got.fault_value);
    endfunction
endclass

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    stroke_tracker seq_track;
    bit            steady      = 1'b0;   // no stalls on either side while set
    int unsigned   cycles      = 0;
    int unsigned   events_sent = 0;

    always #2 aclk = ~aclk;

    stroke_cycle_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random back-pressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 27);
    end

    always @(posedge aclk) begin : sample_result
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.command_valid   = m_tuser;
            got.target_position = m_tdata[7:0];
            got.target_speed    = m_tdata[14:8];
            got.phase           = m_tdata[17:15];
            got.stroke_index    = m_tdata[25:18];
            got.extending       = m_tdata[26];
            got.pending         = m_tdata[27];
            got.fault_value     = m_tdata[35:28];
            seq_track.check_status(got);
        end
    end

    // one event beat; returns at the edge that accepted it
    task automatic send_event(logic [2:0] req, logic [7:0] code);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 27) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, code, req};
        do @(posedge aclk); while (!s_tready);
        seq_track.note_event(req, code);
        if (req <= REQ_TAKE) events_sent++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge aclk); while (!cfg_ready);
        seq_track.set_reg(idx, d);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // upper bits of the 8-bit registers carry junk, which must be ignored
    task automatic write_all(cfg_t c);
        logic [7:0]  vals [7];
        logic [31:0] junk;
        vals = '{c.travel_length, c.short_count, c.short_length, c.long_count,
                 c.long_length, c.position_speed, c.fast_count};
        for (int i = 0; i < 7; i++) begin
            junk = $urandom();
            write_reg(cfg_idx_t'(3'(i)), {junk[31:8], vals[i]});
        end
        write_reg(CFG_STROKE_SPEEDS, c.stroke_speeds);
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (seq_track.status_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.travel_length   = 8'($urandom_range(0, 255));
        c.short_count     = ($urandom_range(99) < 75) ? 8'($urandom_range(0, 6))
                                                      : 8'($urandom_range(0, 255));
        c.short_length    = 8'($urandom_range(0, 255));
        c.long_count      = ($urandom_range(99) < 75) ? 8'($urandom_range(0, 6))
                                                      : 8'($urandom_range(0, 255));
        c.long_length     = 8'($urandom_range(0, 255));
        c.position_speed  = 8'($urandom_range(0, 255));
        c.fast_count      = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 8))
                                                      : 8'($urandom_range(0, 255));
        c.stroke_speeds   = $urandom();
        return c;
    endfunction

    // mostly full start / home / take / move cycles, some noise and faults
    task automatic run_sequences(int unsigned n);
        int unsigned stop_at;
        int unsigned steps;
        int unsigned r;
        stop_at = events_sent + n;
        while (events_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                send_event(REQ_START, 8'($urandom()));
                if ($urandom_range(99) < 10)
                    send_event(3'($urandom_range(0, 7)), 8'($urandom()));
                send_event(REQ_HOME_DONE, 8'($urandom()));
                steps = 0;
                while ((seq_track.ph == CODE_POSITION || seq_track.ph == CODE_SHORT ||
                        seq_track.ph == CODE_LONG) && steps < 24) begin
                    r = $urandom_range(99);
                    if (r < 3) begin
                        send_event(REQ_FAULT, 8'($urandom()));
                    end else if (r < 13) begin
                        // move done with the command never taken
                        send_event(REQ_MOVE_DONE, 8'($urandom()));
                    end else begin
                        send_event(REQ_TAKE, 8'($urandom()));
                        if (r >= 90) send_event(REQ_TAKE, 8'($urandom()));
                        send_event(REQ_MOVE_DONE, 8'($urandom()));
                    end
                    steps++;
                end
                if ($urandom_range(99) < 50) send_event(REQ_TAKE, 8'($urandom()));
            end else begin
                send_event(3'($urandom_range(0, 7)), 8'($urandom()));
            end
        end
    endtask

    initial begin
        cfg_t c;
        seq_track = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: a full pass through both stroke phases
        send_event(REQ_TAKE, 8'h00);          // take with nothing waiting
        send_event(REQ_MOVE_DONE, 8'h00);     // ignored while idle
        send_event(REQ_HOME_DONE, 8'h00);     // acted on even while idle
        send_event(REQ_START, 8'hFF);
        send_event(REQ_MOVE_DONE, 8'h00);     // ignored while homing
        send_event(REQ_HOME_DONE, 8'h00);
        send_event(REQ_TAKE, 8'h00);
        send_event(REQ_MOVE_DONE, 8'h00);
        send_event(REQ_TAKE, 8'h00);
        repeat (7) send_event(REQ_MOVE_DONE, 8'h00);
        send_event(REQ_TAKE, 8'h00);
        send_event(REQ_MOVE_DONE, 8'h00);     // sequence ends, pending dropped
        send_event(REQ_TAKE, 8'h00);
        send_event(REQ_FAULT, 8'hFF);
        send_event(REQ_TAKE, 8'h00);
        send_event(REQ_MOVE_DONE, 8'h00);     // ignored in fault
        for (int i = 5; i < 8; i++) send_event(3'(i), 8'hA5);
        send_event(REQ_HOME_DONE, 8'h00);     // leaves fault
        send_event(REQ_FAULT, 8'h00);
        send_event(REQ_START, 8'h00);         // clears the stored fault
        send_event(REQ_HOME_DONE, 8'h00);     // leaves a command waiting

        // all zero: nothing enabled, home done keeps the waiting command
        wait_idle();
        write_all('0);
        send_event(REQ_HOME_DONE, 8'h00);
        send_event(REQ_TAKE, 8'h00);
        send_event(REQ_MOVE_DONE, 8'h00);
        run_sequences(12);

        // short phase off by length; long turned off while positioning
        wait_idle();
        c = CFG_RESET;
        c.short_length = 8'd0;
        write_all(c);
        send_event(REQ_START, 8'h00);
        send_event(REQ_HOME_DONE, 8'h00);
        wait_idle();
        write_reg(CFG_LONG_COUNT, 32'h0000_0000);
        send_event(REQ_MOVE_DONE, 8'h00);     // long stroke one still queued
        send_event(REQ_TAKE, 8'h00);
        send_event(REQ_MOVE_DONE, 8'h00);

        // all ones
        wait_idle();
        write_all('1);
        run_sequences(20);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_all(random_cfg());
            steady = (p == 3);
            run_sequences(55);
        end

        wait_idle();
        if (seq_track.errors == 0 && seq_track.status_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/scs_pkg.sv
design/scs_step.sv
design/stroke_cycle_sequencer.sv
tb/tb.sv
